>>> rtl/lfpd_pkg.sv
// Shared types, widths, reset values and codes for the line follower PD mixer.
// No dependencies; every other file of the block imports this package.
package lfpd_pkg;

  // Fixed-point format and sensor array
  localparam int unsigned POS_FRAC_BITS = 8;
  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned NUM_SENSORS   = 6;

  // Configuration register widths
  localparam int unsigned THRESH_W   = 12;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned SETPOINT_W = 11;
  localparam int unsigned LIMIT_W    = 10;
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;

  // Datapath widths
  localparam int unsigned WSUM_W     = 5;   // sum of weights 1..6
  localparam int unsigned COUNT_W    = 3;   // number of sensors that see the line
  localparam int unsigned DIVIDEND_W = WSUM_W + POS_FRAC_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int unsigned POS_W      = 11;
  localparam int unsigned ERR_W      = 12;
  localparam int unsigned DIFF_W     = ERR_W + 1;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned ACC_W      = 24;
  localparam int unsigned CTL_W      = LIMIT_W + POS_FRAC_BITS + 1;
  localparam int unsigned MIX_W      = CTL_W + 1;
  localparam int unsigned DUTY_W     = 10;

  // Reset values of the configuration registers
  localparam logic [THRESH_W-1:0]   THRESH_RST   = THRESH_W'(3000);
  localparam logic [GAIN_W-1:0]     KP_RST       = GAIN_W'(225);
  localparam logic [GAIN_W-1:0]     KD_RST       = GAIN_W'(225);
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST = SETPOINT_W'(896);
  localparam logic [LIMIT_W-1:0]    LIMIT_RST    = LIMIT_W'(500);
  localparam logic [SPEED_W-1:0]    SPEED_RST    = SPEED_W'(250);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_KP_GAIN   = 3'd1,
    CFG_KD_GAIN   = 3'd2,
    CFG_SETPOINT  = 3'd3,
    CFG_LIMIT     = 3'd4,
    CFG_BASE      = 3'd5
  } cfg_idx_e;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_START  = 9'b000000010,
    ST_DIVIDE = 9'b000000100,
    ST_ERR    = 9'b000001000,
    ST_PROD_P = 9'b000010000,
    ST_PROD_D = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_CLAMP  = 9'b010000000,
    ST_MIX    = 9'b100000000
  } state_e;

  // Input item
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_one;
    logic [SAMPLE_BITS-1:0] sample_two;
    logic [SAMPLE_BITS-1:0] sample_three;
    logic [SAMPLE_BITS-1:0] sample_four;
    logic [SAMPLE_BITS-1:0] sample_five;
    logic [SAMPLE_BITS-1:0] sample_six;
  } in_t;

  // Result item
  typedef struct packed {
    logic              left_reverse;
    logic [DUTY_W-1:0] left_duty;
    logic              right_reverse;
    logic [DUTY_W-1:0] right_duty;
    logic              line_lost;
    logic [POS_W-1:0]  position;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
    logic pos_hold;
    logic pos_take;
    logic err_calc;
    logic prod_p;
    logic prod_d;
    logic sum;
    logic clamp;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lost;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/lfpd_div.sv
// Iterative restoring divider for the line position: one quotient bit a cycle.
// Depends on lfpd_pkg for widths.
module lfpd_div import lfpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [COUNT_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic                  busy_q, done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVIDEND_W-1:0] num_q;
  logic [COUNT_W-1:0]    rem_q;
  logic [COUNT_W:0]      trial;
  logic [COUNT_W:0]      trial_sub;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try the subtract
  assign trial     = {rem_q, num_q[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, divisor_i};
  assign fits      = (trial >= {1'b0, divisor_i});

  // Step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Quotient bits replace dividend bits as they are consumed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

>>> rtl/lfpd_ctrl.sv
// Sequencing state machine of the line follower PD mixer.
// Depends on lfpd_pkg for the state enum and the command and status structs.
module lfpd_ctrl import lfpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (status_i.lost) begin
          cmd_o.pos_hold = 1'b1;
          state_d        = ST_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.pos_take = 1'b1;
          state_d        = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.err_calc = 1'b1;
        state_d        = ST_PROD_P;
      end
      ST_PROD_P: begin
        cmd_o.prod_p = 1'b1;
        state_d      = ST_PROD_D;
      end
      ST_PROD_D: begin
        cmd_o.prod_d = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_MIX;
      end
      ST_MIX: begin
        // hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/lfpd_datapath.sv
// Datapath of the line follower PD mixer: configuration, position, PD term,
// clamp, motor mixing and result register. Depends on lfpd_pkg and lfpd_div.
module lfpd_datapath import lfpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_t                   in_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  localparam int unsigned LIM_PAD  = ACC_W - LIMIT_W - POS_FRAC_BITS;
  localparam int unsigned BASE_PAD = MIX_W - SPEED_W - POS_FRAC_BITS;

  // Configuration registers
  logic [THRESH_W-1:0]   thresh_q;
  logic [GAIN_W-1:0]     kp_q, kd_q;
  logic [SETPOINT_W-1:0] setpoint_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic [SPEED_W-1:0]    base_q;

  // Item registers
  logic [WSUM_W-1:0]        wsum_q;
  logic [COUNT_W-1:0]       count_q;
  logic                     lost_q;
  logic [POS_W-1:0]         pos_q, prev_pos_q;
  logic signed [ERR_W-1:0]  err_q, prev_err_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [CTL_W-1:0]  ctl_q;
  out_t                     out_q;
  logic                     out_valid_q;

  // Combinational terms
  logic [SAMPLE_BITS-1:0]   samples [NUM_SENSORS];
  logic [WSUM_W-1:0]        wsum_d;
  logic [COUNT_W-1:0]       count_d;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    quotient;
  logic signed [ERR_W:0]    err_full;
  logic signed [DIFF_W-1:0] diff_d;
  logic [GAIN_W-1:0]        mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  lim_s;
  logic signed [ACC_W-1:0]  ctl_d;
  logic signed [MIX_W-1:0]  c_s, b_s, l_mag, r_mag;
  logic                     l_rev, r_rev;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= THRESH_RST;
      kp_q       <= KP_RST;
      kd_q       <= KD_RST;
      setpoint_q <= SETPOINT_RST;
      limit_q    <= LIMIT_RST;
      base_q     <= SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thresh_q   <= cfg_data_i[THRESH_W-1:0];
        CFG_KP_GAIN:   kp_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_KD_GAIN:   kd_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_SETPOINT:  setpoint_q <= cfg_data_i[SETPOINT_W-1:0];
        CFG_LIMIT:     limit_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_BASE:      base_q     <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Threshold the samples and form the weighted sum and the count
  assign samples[0] = in_data_i.sample_one;
  assign samples[1] = in_data_i.sample_two;
  assign samples[2] = in_data_i.sample_three;
  assign samples[3] = in_data_i.sample_four;
  assign samples[4] = in_data_i.sample_five;
  assign samples[5] = in_data_i.sample_six;

  always_comb begin
    wsum_d  = '0;
    count_d = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (samples[i] > thresh_q) begin
        wsum_d  = wsum_d + WSUM_W'(i + 1);
        count_d = count_d + 1'b1;
      end
    end
  end

  // Weighted mean by iterative division
  lfpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({wsum_q, {POS_FRAC_BITS{1'b0}}}),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Error, difference and one shared multiplier
  assign err_full = $signed({2'b00, setpoint_q}) - $signed({2'b00, pos_q});
  assign diff_d   = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
  assign mul_a    = cmd_i.prod_d ? kd_q : kp_q;
  assign mul_b    = cmd_i.prod_d ? diff_q : {err_q[ERR_W-1], err_q};
  assign mul_p    = $signed({1'b0, mul_a}) * mul_b;

  // Clamp to plus or minus the limit
  assign lim_s = $signed({{LIM_PAD{1'b0}}, limit_q, {POS_FRAC_BITS{1'b0}}});
  always_comb begin
    if (acc_q > lim_s) begin
      ctl_d = lim_s;
    end else if (acc_q < -lim_s) begin
      ctl_d = -lim_s;
    end else begin
      ctl_d = acc_q;
    end
  end

  // Mix the control around the base speed
  assign c_s = {ctl_q[CTL_W-1], ctl_q};
  assign b_s = $signed({{BASE_PAD{1'b0}}, base_q, {POS_FRAC_BITS{1'b0}}});
  always_comb begin
    l_rev = 1'b0;
    r_rev = 1'b0;
    if (c_s > 0) begin
      r_mag = b_s;
      if (c_s > b_s) begin
        l_rev = 1'b1;
        l_mag = c_s - b_s;
      end else begin
        l_mag = b_s - c_s;
      end
    end else begin
      l_mag = b_s;
      if (c_s < -b_s) begin
        r_rev = 1'b1;
        r_mag = -(c_s + b_s);
      end else begin
        r_mag = b_s + c_s;
      end
    end
  end

  // Item pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wsum_q  <= wsum_d;
      count_q <= count_d;
      lost_q  <= (count_d == '0);
    end
    if (cmd_i.pos_hold) begin
      pos_q <= prev_pos_q;
    end else if (cmd_i.pos_take) begin
      pos_q <= quotient[POS_W-1:0];
    end
    if (cmd_i.err_calc) begin
      err_q <= err_full[ERR_W-1:0];
    end
    if (cmd_i.prod_p) begin
      diff_q <= diff_d;
    end
    if (cmd_i.prod_p || cmd_i.prod_d) begin
      prod_q <= mul_p;
    end
    if (cmd_i.prod_d) begin
      acc_q <= prod_q;
    end else if (cmd_i.sum) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.clamp) begin
      ctl_q <= ctl_d[CTL_W-1:0];
    end
    if (cmd_i.commit) begin
      out_q.left_reverse  <= l_rev;
      out_q.left_duty     <= l_mag[POS_FRAC_BITS +: DUTY_W];
      out_q.right_reverse <= r_rev;
      out_q.right_duty    <= r_mag[POS_FRAC_BITS +: DUTY_W];
      out_q.line_lost     <= lost_q;
      out_q.position      <= pos_q;
    end
  end

  // Carried state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q  <= '0;
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        prev_pos_q  <= pos_q;
        prev_err_q  <= err_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.lost     = lost_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

>>> rtl/line_follower_pd_motor_mixer.sv
// Line follower PD controller with differential-drive motor mixing.
// Top level: joins lfpd_ctrl and lfpd_datapath; depends on lfpd_pkg.
//
// Use: each input item carries six 12-bit reflectance samples of one control
// tick; each accepted item gives exactly one result item with the direction
// and duty of both motors, the line-lost flag and the position used.
// Both channels are valid/ready. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), taken at once; write it only while idle.
// Sequence: with the line seen the item is loaded, the 13-step bit-serial
// divider forms the weighted mean, and then the error, the P and D products
// of one shared multiplier, their sum, the clamp and the mix follow. With
// the line lost the divider is skipped and the previous position is held.
// One item is worked on at a time, and the next is taken as soon as the
// result is stored.
// Stall: a finished result waits in the output register; the next item is
// still accepted and worked on, and holds in its last step until the
// receiver takes the earlier result.
// Reset: configuration returns to its defaults, previous position and error
// clear to zero, and no result is pending.
module line_follower_pd_motor_mixer import lfpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  cmd_t    cmd;
  status_t status;

  lfpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfpd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A result is only stored when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> status.out_free)
    else $error("result stored over a pending item");

  // A stored result shows valid in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("stored result not presented");

  // An accepted item closes the input until it is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // The divider never runs for a lost line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.lost)
    else $error("divide started with no sensor set");

endmodule
